/* hw/rtl/sorted_k_way_change_merge_top_macros.svh */
// ----------------------------------------------------------------------------
// Sorted k-way change merge: assertion macros
// Shared property wrappers for the checker of the merge block.
// ----------------------------------------------------------------------------
`ifndef SORTED_K_WAY_CHANGE_MERGE_TOP_MACROS_SVH
`define SORTED_K_WAY_CHANGE_MERGE_TOP_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define SKWCM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("merge block property violated");

// Property checked at every rising clock edge, reset included.
`define SKWCM_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("merge block property violated");

`endif

/* hw/rtl/skwcm_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted k-way change merge: package
// Widths, codes and the command and status types shared by the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skwcm_pkg;

   localparam int MAX_LAYERS  = 16;
   localparam int POS_W       = 31;
   localparam int LAYER_W     = 4;
   localparam int FUNC_W      = 2;
   localparam int KIND_W      = 2;
   localparam int CNT_W       = $clog2(MAX_LAYERS + 1);
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = POS_W;

   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [LAYER_W-1:0] layer_type;
   typedef logic [CNT_W-1:0]   cnt_type;

   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RUN    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ANSWER = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHANGE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_START = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END   = 1'b1;

   // What the captured item leads to once it has been applied.
   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_ERROR = 2'd1,
      MODE_BEGIN = 2'd2,
      MODE_AFTER = 2'd3
   } mode_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load_error;
      logic load_after;
      logic load_begin;
   } dp_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     after_more;
   } dp_status_type;

endpackage

/* hw/rtl/skwcm_dp.sv */
// ----------------------------------------------------------------------------
// Sorted k-way change merge: datapath
// Sorted entry row with compare-shift insert and head re-sort, scan state,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skwcm_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  skwcm_pkg::dp_cmd_type                 cmd,
   output skwcm_pkg::dp_status_type              status,
   input  logic [skwcm_pkg::FUNC_W-1:0]          req_func,
   input  skwcm_pkg::layer_type                  req_layer_id,
   input  skwcm_pkg::pos_type                    req_position,
   input  logic                                  csr_write,
   input  logic [skwcm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [skwcm_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic [skwcm_pkg::KIND_W-1:0]          rsp_kind,
   output skwcm_pkg::layer_type                  rsp_req_layer,
   output skwcm_pkg::pos_type                    rsp_change_position,
   output logic                                  rsp_last
);

   logic [skwcm_pkg::FUNC_W-1:0] item_func_ff;
   skwcm_pkg::layer_type         item_layer_ff;
   skwcm_pkg::pos_type           item_pos_ff;

   skwcm_pkg::pos_type           start_ff, start_in;
   skwcm_pkg::pos_type           end_ff, end_in;

   skwcm_pkg::pos_type           entry_pos_ff   [skwcm_pkg::MAX_LAYERS];
   skwcm_pkg::pos_type           entry_pos_in   [skwcm_pkg::MAX_LAYERS];
   skwcm_pkg::layer_type         entry_layer_ff [skwcm_pkg::MAX_LAYERS];
   skwcm_pkg::layer_type         entry_layer_in [skwcm_pkg::MAX_LAYERS];
   skwcm_pkg::cnt_type           count_ff, count_in;
   skwcm_pkg::pos_type           cc_ff, cc_in;
   logic                         scanning_ff, scanning_in;

   logic [skwcm_pkg::KIND_W-1:0] kind_ff, kind_in;
   skwcm_pkg::layer_type         out_layer_ff, out_layer_in;
   skwcm_pkg::pos_type           out_pos_ff, out_pos_in;
   logic                         last_ff, last_in;

   // Neighbor views of the row so that each cell only looks one place away.
   logic [skwcm_pkg::MAX_LAYERS-1:0] lt;
   logic [skwcm_pkg::MAX_LAYERS-1:0] lt_prev;
   logic [skwcm_pkg::MAX_LAYERS-1:0] lt_next;
   skwcm_pkg::pos_type               prev_pos   [skwcm_pkg::MAX_LAYERS];
   skwcm_pkg::layer_type             prev_layer [skwcm_pkg::MAX_LAYERS];
   skwcm_pkg::pos_type               next_pos   [skwcm_pkg::MAX_LAYERS];
   skwcm_pkg::layer_type             next_layer [skwcm_pkg::MAX_LAYERS];

   skwcm_pkg::pos_type               head_pos;
   skwcm_pkg::layer_type             head_layer;
   logic                             full;
   logic                             empty;
   logic                             run_ok;
   logic                             adv_more;
   logic                             cc_final;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_func_ff  <= req_func;
         item_layer_ff <= req_layer_id;
         item_pos_ff   <= req_position;
      end
   end

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      if (csr_write) begin
         unique case (csr_index)
            skwcm_pkg::CSR_START: start_in = csr_data;
            skwcm_pkg::CSR_END:   end_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '0;
      end else begin
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

   assign head_pos   = entry_pos_ff[0];
   assign head_layer = entry_layer_ff[0];
   assign full       = (count_ff >= skwcm_pkg::cnt_type'(skwcm_pkg::MAX_LAYERS));
   assign empty      = (count_ff == '0);
   assign run_ok     = (start_ff < end_ff);
   assign adv_more   = (head_pos < end_ff) && (head_pos <= cc_ff);
   assign cc_final   = (cc_ff >= end_ff);

   // Each held cell compares its position with the item's position. The row
   // is sorted, so the set of cells below the item's position is a prefix.
   always_comb begin
      for (int i = 0; i < skwcm_pkg::MAX_LAYERS; i++) begin
         lt[i] = (skwcm_pkg::cnt_type'(i) < count_ff) && (entry_pos_ff[i] < item_pos_ff);
      end
      lt_prev[0]    = 1'b1;
      prev_pos[0]   = entry_pos_ff[0];
      prev_layer[0] = entry_layer_ff[0];
      for (int i = 1; i < skwcm_pkg::MAX_LAYERS; i++) begin
         lt_prev[i]    = lt[i-1];
         prev_pos[i]   = entry_pos_ff[i-1];
         prev_layer[i] = entry_layer_ff[i-1];
      end
      for (int i = 0; i < skwcm_pkg::MAX_LAYERS - 1; i++) begin
         lt_next[i]    = lt[i+1];
         next_pos[i]   = entry_pos_ff[i+1];
         next_layer[i] = entry_layer_ff[i+1];
      end
      lt_next[skwcm_pkg::MAX_LAYERS-1]    = 1'b0;
      next_pos[skwcm_pkg::MAX_LAYERS-1]   = entry_pos_ff[skwcm_pkg::MAX_LAYERS-1];
      next_layer[skwcm_pkg::MAX_LAYERS-1] = entry_layer_ff[skwcm_pkg::MAX_LAYERS-1];
   end

   always_comb begin
      status.mode = skwcm_pkg::MODE_NONE;
      unique case (item_func_ff)
         skwcm_pkg::FUNC_ADD: begin
            if (!scanning_ff && full) begin
               status.mode = skwcm_pkg::MODE_ERROR;
            end
         end
         skwcm_pkg::FUNC_RUN: begin
            if (!scanning_ff && run_ok) begin
               status.mode = empty ? skwcm_pkg::MODE_ERROR : skwcm_pkg::MODE_BEGIN;
            end
         end
         skwcm_pkg::FUNC_ANSWER: begin
            if (scanning_ff && !empty) begin
               status.mode = skwcm_pkg::MODE_AFTER;
            end
         end
         default: ;
      endcase
      // A change that is not final is followed by the start of the next one.
      status.after_more = !adv_more && !cc_final;
   end

   always_comb begin
      entry_pos_in   = entry_pos_ff;
      entry_layer_in = entry_layer_ff;
      count_in       = count_ff;
      cc_in          = cc_ff;
      scanning_in    = scanning_ff;
      kind_in        = kind_ff;
      out_layer_in   = out_layer_ff;
      out_pos_in     = out_pos_ff;
      last_in        = last_ff;

      if (cmd.exec) begin
         case (item_func_ff)
            skwcm_pkg::FUNC_ADD: begin
               if (!scanning_ff && !full) begin
                  // Cells at or above the item's place move up by one.
                  for (int i = 0; i < skwcm_pkg::MAX_LAYERS; i++) begin
                     if (!lt[i]) begin
                        if (lt_prev[i]) begin
                           entry_pos_in[i]   = item_pos_ff;
                           entry_layer_in[i] = item_layer_ff;
                        end else begin
                           entry_pos_in[i]   = prev_pos[i];
                           entry_layer_in[i] = prev_layer[i];
                        end
                     end
                  end
                  count_in = count_ff + skwcm_pkg::cnt_type'(1);
               end
            end
            skwcm_pkg::FUNC_RUN: begin
               if (!scanning_ff) begin
                  if (!run_ok) begin
                     count_in    = '0;
                     scanning_in = 1'b0;
                  end else if (!empty) begin
                     scanning_in = 1'b1;
                  end
               end
            end
            skwcm_pkg::FUNC_ANSWER: begin
               if (scanning_ff && !empty) begin
                  // The head takes its new position and sinks past every
                  // cell that now lies below it; those cells move down.
                  for (int i = 0; i < skwcm_pkg::MAX_LAYERS; i++) begin
                     if (lt_next[i]) begin
                        entry_pos_in[i]   = next_pos[i];
                        entry_layer_in[i] = next_layer[i];
                     end else if ((i == 0) || lt[i]) begin
                        entry_pos_in[i]   = item_pos_ff;
                        entry_layer_in[i] = head_layer;
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      if (cmd.load_error) begin
         kind_in      = skwcm_pkg::KIND_ERROR;
         out_layer_in = '0;
         out_pos_in   = '0;
         last_in      = 1'b1;
      end

      if (cmd.load_after) begin
         if (adv_more) begin
            kind_in      = skwcm_pkg::KIND_ADVANCE;
            out_layer_in = head_layer;
            out_pos_in   = '0;
            last_in      = 1'b0;
         end else begin
            kind_in      = skwcm_pkg::KIND_CHANGE;
            out_layer_in = '0;
            out_pos_in   = cc_ff;
            last_in      = cc_final;
            if (cc_final) begin
               count_in    = '0;
               scanning_in = 1'b0;
            end
         end
      end

      if (cmd.load_begin) begin
         cc_in = head_pos;
         if (head_pos < end_ff) begin
            kind_in      = skwcm_pkg::KIND_ADVANCE;
            out_layer_in = head_layer;
            out_pos_in   = '0;
            last_in      = 1'b0;
         end else begin
            kind_in      = skwcm_pkg::KIND_CHANGE;
            out_layer_in = '0;
            out_pos_in   = head_pos;
            last_in      = 1'b1;
            count_in     = '0;
            scanning_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_pos_ff   <= entry_pos_in;
      entry_layer_ff <= entry_layer_in;
      kind_ff        <= kind_in;
      out_layer_ff   <= out_layer_in;
      out_pos_ff     <= out_pos_in;
      last_ff        <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         cc_ff       <= '0;
         scanning_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         cc_ff       <= cc_in;
         scanning_ff <= scanning_in;
      end
   end

   assign rsp_kind            = kind_ff;
   assign rsp_req_layer       = out_layer_ff;
   assign rsp_change_position = out_pos_ff;
   assign rsp_last            = last_ff;

endmodule

/* hw/rtl/skwcm_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted k-way change merge: controller
// Sequences capture, execution and result loads, and runs both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skwcm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output skwcm_pkg::dp_cmd_type    cmd,
   input  skwcm_pkg::dp_status_type status
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_AFTER = 5'b00100,
      S_BEGIN = 5'b01000,
      S_WAIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      pending_ff, pending_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_WAIT);

   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            unique case (status.mode)
               skwcm_pkg::MODE_NONE:  state_in = S_IDLE;
               skwcm_pkg::MODE_ERROR: begin
                  cmd.load_error = 1'b1;
                  state_in       = S_WAIT;
               end
               skwcm_pkg::MODE_BEGIN: state_in = S_BEGIN;
               skwcm_pkg::MODE_AFTER: state_in = S_AFTER;
               default:               state_in = S_IDLE;
            endcase
         end
         S_AFTER: begin
            cmd.load_after = 1'b1;
            pending_in     = status.after_more;
            state_in       = S_WAIT;
         end
         S_BEGIN: begin
            cmd.load_begin = 1'b1;
            pending_in     = 1'b0;
            state_in       = S_WAIT;
         end
         S_WAIT: begin
            // A non-final change is followed by the next change's first result.
            if (!rsp_stall) begin
               state_in = pending_ff ? S_BEGIN : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
      end
   end

endmodule

/* hw/rtl/sorted_k_way_change_merge_top.sv */
// ----------------------------------------------------------------------------
// Sorted k-way change merge: top level
// Order: an item without a result goes from capture through execution back to
// idle; an error result is loaded during execution, a run's or an answer's first
// result in a load state after it. One item at a time: a request is taken only
// in idle, so a stalled result holds off the next one; a change that is not
// final is followed by the next change's first result before idle.
// Reset is synchronous and active high; it empties the list and stops any scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_k_way_change_merge_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [skwcm_pkg::FUNC_W-1:0]          req_func,
   input  logic [skwcm_pkg::LAYER_W-1:0]         req_layer_id,
   input  logic [skwcm_pkg::POS_W-1:0]           req_position,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [skwcm_pkg::KIND_W-1:0]          rsp_kind,
   output logic [skwcm_pkg::LAYER_W-1:0]         rsp_req_layer,
   output logic [skwcm_pkg::POS_W-1:0]           rsp_change_position,
   output logic                                  rsp_last,
   input  logic                                  csr_write,
   input  logic [skwcm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [skwcm_pkg::CSR_DATA_W-1:0]      csr_data
);

   skwcm_pkg::dp_cmd_type    cmd;
   skwcm_pkg::dp_status_type status;

   skwcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   skwcm_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_func            (req_func),
      .req_layer_id        (req_layer_id),
      .req_position        (req_position),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_kind            (rsp_kind),
      .rsp_req_layer       (rsp_req_layer),
      .rsp_change_position (rsp_change_position),
      .rsp_last            (rsp_last)
   );

endmodule

/* hw/rtl/skwcm_checker.sv */
// ----------------------------------------------------------------------------
// Sorted k-way change merge: port checker
// Properties over the top level's ports, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_k_way_change_merge_top_macros.svh"

module skwcm_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [skwcm_pkg::KIND_W-1:0]          rsp_kind,
   input logic [skwcm_pkg::LAYER_W-1:0]         rsp_req_layer,
   input logic [skwcm_pkg::POS_W-1:0]           rsp_change_position,
   input logic                                  rsp_last
);

   logic [skwcm_pkg::KIND_W+skwcm_pkg::LAYER_W+skwcm_pkg::POS_W:0] rsp_bundle;
   logic                                                           is_error;
   logic                                                           is_advance;
   logic                                                           no_payload;

   assign rsp_bundle = {rsp_kind, rsp_req_layer, rsp_change_position, rsp_last};
   assign is_error   = rsp_valid && (rsp_kind == skwcm_pkg::KIND_ERROR);
   assign is_advance = rsp_valid && (rsp_kind == skwcm_pkg::KIND_ADVANCE);
   assign no_payload = (rsp_req_layer == '0) && (rsp_change_position == '0);

   // A stalled result stays offered and unchanged.
   `SKWCM_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_bundle)))

   // Only one item is in work: no transfer in while a result is offered.
   `SKWCM_ASSERT(a_one_item, clock, reset, rsp_valid |-> req_stall)

   // The cycle after a transfer in is always spent executing the item.
   `SKWCM_ASSERT(a_exec_after_in, clock, reset, (req_valid && !req_stall) |=> req_stall)

   // An error ends the run and carries no layer and no position.
   `SKWCM_ASSERT(a_error_shape, clock, reset, is_error |-> (rsp_last && no_payload))

   // An advance request never ends the run and carries no position.
   `SKWCM_ASSERT(a_advance_shape, clock, reset, is_advance |-> (!rsp_last && rsp_change_position == '0))

endmodule

bind sorted_k_way_change_merge_top skwcm_checker u_checker (.*);

/* sim/sorted_k_way_change_merge_checker.sv */
// ----------------------------------------------------------------------------
// Sorted k-way change merge: result checker
// Watches the request, result and register ports of the merge block, keeps
// its own sorted list of layers and predicts every result, then compares each
// result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_k_way_change_merge_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [skwcm_pkg::FUNC_W-1:0]        req_func,
   input  skwcm_pkg::layer_type                req_layer_id,
   input  skwcm_pkg::pos_type                  req_position,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [skwcm_pkg::KIND_W-1:0]        rsp_kind,
   input  skwcm_pkg::layer_type                rsp_req_layer,
   input  skwcm_pkg::pos_type                  rsp_change_position,
   input  logic                                rsp_last,
   input  logic                                csr_write,
   input  logic [skwcm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [skwcm_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                  fail_count,
   output int                                  waiting_count
);

   typedef struct packed {
      logic [skwcm_pkg::KIND_W-1:0] kind;
      skwcm_pkg::layer_type         layer;
      skwcm_pkg::pos_type           pos;
      logic                         last;
   } merge_result_type;

   merge_result_type awaited_results[$];

   skwcm_pkg::layer_type held_layer[skwcm_pkg::MAX_LAYERS];
   skwcm_pkg::pos_type   held_pos[skwcm_pkg::MAX_LAYERS];
   int unsigned          held_count;
   skwcm_pkg::pos_type   change_pos;
   bit                   scan_on;
   skwcm_pkg::pos_type   scan_start;
   skwcm_pkg::pos_type   scan_end;

   initial begin
      fail_count    = 0;
      waiting_count = 0;
   end

   function automatic void await_result(input logic [skwcm_pkg::KIND_W-1:0] kind,
                                        input skwcm_pkg::layer_type layer,
                                        input skwcm_pkg::pos_type pos, input logic last);
      merge_result_type r;
      r.kind  = kind;
      r.layer = layer;
      r.pos   = pos;
      r.last  = last;
      awaited_results.push_back(r);
   endfunction

   function automatic void drop_list();
      held_count = 0;
      scan_on    = 1'b0;
   endfunction

   // The head becomes the change being collected; it is final when at or past the end.
   function automatic void open_change();
      change_pos = held_pos[0];
      if (held_pos[0] < scan_end) begin
         await_result(skwcm_pkg::KIND_ADVANCE, held_layer[0], '0, 1'b0);
      end else begin
         await_result(skwcm_pkg::KIND_CHANGE, '0, change_pos, 1'b1);
         drop_list();
      end
   endfunction

   function automatic void predict_merge_results(input logic [skwcm_pkg::FUNC_W-1:0] func,
                                                 input skwcm_pkg::layer_type id,
                                                 input skwcm_pkg::pos_type pos);
      int unsigned          i;
      int unsigned          j;
      skwcm_pkg::layer_type head_layer;
      case (func)
         skwcm_pkg::FUNC_ADD: begin
            if (!scan_on) begin
               if (held_count >= skwcm_pkg::MAX_LAYERS) begin
                  await_result(skwcm_pkg::KIND_ERROR, '0, '0, 1'b1);
               end else begin
                  // A new entry lands in front of any entry with the same position.
                  i = 0;
                  while (i < held_count && held_pos[i] < pos) i++;
                  for (j = held_count; j > i; j--) begin
                     held_pos[j]   = held_pos[j-1];
                     held_layer[j] = held_layer[j-1];
                  end
                  held_pos[i]   = pos;
                  held_layer[i] = id;
                  held_count++;
               end
            end
         end
         skwcm_pkg::FUNC_RUN: begin
            if (!scan_on) begin
               if (scan_start >= scan_end) begin
                  drop_list();
               end else if (held_count == 0) begin
                  await_result(skwcm_pkg::KIND_ERROR, '0, '0, 1'b1);
               end else begin
                  scan_on = 1'b1;
                  open_change();
               end
            end
         end
         skwcm_pkg::FUNC_ANSWER: begin
            if (scan_on && held_count != 0) begin
               head_layer  = held_layer[0];
               held_pos[0] = pos;
               if (held_count > 1 && pos > held_pos[1]) begin
                  j = 1;
                  while (j < held_count && held_pos[j] < pos) j++;
                  for (i = 1; i < j; i++) begin
                     held_pos[i-1]   = held_pos[i];
                     held_layer[i-1] = held_layer[i];
                  end
                  held_pos[j-1]   = pos;
                  held_layer[j-1] = head_layer;
               end
               if (held_pos[0] < scan_end && held_pos[0] <= change_pos) begin
                  await_result(skwcm_pkg::KIND_ADVANCE, held_layer[0], '0, 1'b0);
               end else if (change_pos >= scan_end) begin
                  await_result(skwcm_pkg::KIND_CHANGE, '0, change_pos, 1'b1);
                  drop_list();
               end else begin
                  await_result(skwcm_pkg::KIND_CHANGE, '0, change_pos, 1'b0);
                  open_change();
               end
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      merge_result_type want;
      if (reset) begin
         held_count = 0;
         change_pos = '0;
         scan_on    = 1'b0;
         scan_start = '0;
         scan_end   = '0;
         awaited_results.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == skwcm_pkg::CSR_START) scan_start = csr_data;
            else if (csr_index == skwcm_pkg::CSR_END) scan_end = csr_data;
         end
         if (req_valid && !req_stall)
            predict_merge_results(req_func, req_layer_id, req_position);
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("result transfer with nothing expected: kind %0d", rsp_kind);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_req_layer !== want.layer) begin
                  $error("req_layer: expected %0d, got %0d", want.layer, rsp_req_layer);
                  fail_count++;
               end
               if (rsp_change_position !== want.pos) begin
                  $error("change_position: expected %0d, got %0d", want.pos,
                         rsp_change_position);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  fail_count++;
               end
            end
         end
      end
      waiting_count <= awaited_results.size();
   end

endmodule

/* sim/sorted_k_way_change_merge_top_tb.sv */
// ----------------------------------------------------------------------------
// Sorted k-way change merge: testbench top
// Builds layer lists, starts scans and answers every advance request with a
// new head position, across several scan windows, with random gaps on the
// request side and random stalls on the result side. The checker predicts and
// compares; this module drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_k_way_change_merge_top_tb;

   typedef logic [skwcm_pkg::FUNC_W-1:0] func_bits_type;

   localparam func_bits_type      FUNC_UNUSED = 2'd3;
   localparam skwcm_pkg::pos_type POS_TOP     = '1;
   localparam int                 ITEM_TARGET = 1050;
   localparam int                 WINDOWS     = 8;
   localparam int                 LAYER_IDS   = 1 << skwcm_pkg::LAYER_W;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   func_bits_type                          req_func = '0;
   skwcm_pkg::layer_type                   req_layer_id = '0;
   skwcm_pkg::pos_type                     req_position = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic [skwcm_pkg::KIND_W-1:0]           rsp_kind;
   skwcm_pkg::layer_type                   rsp_req_layer;
   skwcm_pkg::pos_type                     rsp_change_position;
   logic                                   rsp_last;
   logic                                   csr_write = 1'b0;
   logic [skwcm_pkg::CSR_INDEX_W-1:0]      csr_index = '0;
   logic [skwcm_pkg::CSR_DATA_W-1:0]       csr_data = '0;

   int fail_count;
   int waiting_count;

   // Scan windows: start and end positions, the extremes among them.
   skwcm_pkg::pos_type window_start[WINDOWS] = '{31'd0, 31'd0, 31'd0, 31'd30, 31'd200,
                                                 31'h7FFF_FFFE, 31'd0, 31'h4000_0000};
   skwcm_pkg::pos_type window_end[WINDOWS]   = '{31'd60, 31'd1, 31'd0, 31'd30, 31'd150,
                                                 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                                 31'h4000_0030};

   skwcm_pkg::pos_type   win_end;
   skwcm_pkg::pos_type   layer_at[LAYER_IDS];
   logic                 scan_waiting = 1'b0;
   skwcm_pkg::layer_type asked_layer = '0;
   bit                   gaps_on = 1'b1;
   logic [1:0]           stall_mode = 2'd0;
   int unsigned          stall_hold = 0;
   int                   sent_items = 0;

   sorted_k_way_change_merge_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_layer_id        (req_layer_id),
      .req_position        (req_position),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_req_layer       (rsp_req_layer),
      .rsp_change_position (rsp_change_position),
      .rsp_last            (rsp_last),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   sorted_k_way_change_merge_checker u_result_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_layer_id        (req_layer_id),
      .req_position        (req_position),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_req_layer       (rsp_req_layer),
      .rsp_change_position (rsp_change_position),
      .rsp_last            (rsp_last),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .fail_count          (fail_count),
      .waiting_count       (waiting_count)
   );

   always #5 clock = ~clock;

   // Result side back-pressure: off, light, or bursty with a few long stalls.
   always @(posedge clock) begin
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
         rsp_stall  <= 1'b1;
      end else begin
         case (stall_mode)
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 9) == 0);
            default: begin
               if ($urandom_range(0, 19) == 0) begin
                  stall_hold <= $urandom_range(5, 40);
                  rsp_stall  <= 1'b1;
               end else begin
                  rsp_stall <= ($urandom_range(0, 2) == 0);
               end
            end
         endcase
      end
   end

   // The last result transfer tells whether the scan waits for an answer, and for which layer.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         scan_waiting <= (rsp_kind == skwcm_pkg::KIND_ADVANCE);
         asked_layer  <= rsp_req_layer;
      end
   end

   function automatic skwcm_pkg::pos_type sat_add(input skwcm_pkg::pos_type a,
                                                  input int unsigned b);
      logic [skwcm_pkg::POS_W:0] s;
      s = a + b;
      return (s > POS_TOP) ? POS_TOP : s[skwcm_pkg::POS_W-1:0];
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Drop valid, scramble the idle payload, and let cycles pass.
   task automatic rest_req(input int cycles);
      req_valid    <= 1'b0;
      req_func     <= func_bits_type'($urandom);
      req_layer_id <= skwcm_pkg::layer_type'($urandom);
      req_position <= skwcm_pkg::pos_type'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic settle();
      rest_req(1);
      while (waiting_count != 0) @(posedge clock);
   endtask

   // Unless results are awaited, valid stays high on return so a following item can go back to back.
   task automatic do_item(input func_bits_type func, input skwcm_pkg::layer_type id,
                          input skwcm_pkg::pos_type pos, input bit wait_results);
      int gap;
      gap = pick_gap();
      if (gap != 0) rest_req(gap);
      req_valid    <= 1'b1;
      req_func     <= func;
      req_layer_id <= id;
      req_position <= pos;
      do @(posedge clock); while (req_stall);
      if (wait_results) settle();
   endtask

   task automatic add_layer(input skwcm_pkg::layer_type id, input skwcm_pkg::pos_type pos);
      do_item(skwcm_pkg::FUNC_ADD, id, pos, 1'b0);
      layer_at[id] = pos;
      sent_items++;
   endtask

   task automatic answer_head(input skwcm_pkg::pos_type pos);
      layer_at[asked_layer] = pos;
      do_item(skwcm_pkg::FUNC_ANSWER, skwcm_pkg::layer_type'($urandom), pos, 1'b1);
      sent_items++;
   endtask

   task automatic set_window(input skwcm_pkg::pos_type start_pos,
                             input skwcm_pkg::pos_type end_pos);
      settle();
      repeat (8) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= skwcm_pkg::CSR_START;
      csr_data  <= start_pos;
      @(posedge clock);
      csr_index <= skwcm_pkg::CSR_END;
      csr_data  <= end_pos;
      @(posedge clock);
      csr_write <= 1'b0;
      win_end = end_pos;
   endtask

   // Answer advance requests until the scan ends; past the budget the head jumps to the end.
   task automatic serve_scan(input int budget);
      int                 used;
      int                 r;
      skwcm_pkg::pos_type cur;
      skwcm_pkg::pos_type nxt;
      used = 0;
      while (scan_waiting) begin
         cur = layer_at[asked_layer];
         r   = $urandom_range(0, 99);
         if (used >= budget)
            nxt = sat_add(win_end, $urandom_range(0, 3));
         else if (r < 10)
            nxt = cur;
         else if (r < 78)
            nxt = sat_add(cur, $urandom_range(1, 4));
         else if (r < 90)
            nxt = sat_add(cur, $urandom_range(5, 24));
         else if (r < 95)
            nxt = (cur > 6) ? skwcm_pkg::pos_type'(cur - $urandom_range(1, 6)) : '0;
         else
            nxt = sat_add(win_end, $urandom_range(0, 2));
         // Adds and runs during a scan must be ignored.
         if ($urandom_range(0, 15) == 0)
            do_item(($urandom_range(0, 1) != 0) ? skwcm_pkg::FUNC_ADD : skwcm_pkg::FUNC_RUN,
                    skwcm_pkg::layer_type'($urandom), skwcm_pkg::pos_type'($urandom), 1'b0);
         answer_head(nxt);
         used++;
      end
   endtask

   function automatic skwcm_pkg::pos_type pick_position();
      int                 r;
      skwcm_pkg::pos_type base;
      r    = $urandom_range(0, 99);
      base = (win_end > 60) ? skwcm_pkg::pos_type'(win_end - 60) : '0;
      if (r < 8) return '0;
      if (r < 14) return POS_TOP;
      if (r < 20) return skwcm_pkg::pos_type'($urandom);
      return sat_add(base, $urandom_range(0, 70));
   endfunction

   task automatic run_scan_round();
      int r;
      int count;
      r = $urandom_range(0, 99);
      if (r < 5) count = 0;
      else if (r < 75) count = $urandom_range(1, 4);
      else if (r < 90) count = $urandom_range(5, 15);
      else count = $urandom_range(16, 17);
      for (int k = 0; k < count; k++)
         add_layer(skwcm_pkg::layer_type'($urandom_range(0, LAYER_IDS - 1)), pick_position());
      if ($urandom_range(0, 7) == 0)
         do_item(($urandom_range(0, 1) != 0) ? FUNC_UNUSED : skwcm_pkg::FUNC_ANSWER,
                 skwcm_pkg::layer_type'($urandom), skwcm_pkg::pos_type'($urandom), 1'b0);
      do_item(skwcm_pkg::FUNC_RUN, skwcm_pkg::layer_type'($urandom),
              skwcm_pkg::pos_type'($urandom), 1'b1);
      sent_items++;
      serve_scan(60);
   endtask

   initial begin
      int sel;
      int phase;
      win_end = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. With both registers at zero a run only clears the list.
      gaps_on = 1'b0;
      do_item(skwcm_pkg::FUNC_RUN, '0, '0, 1'b1);
      set_window('0, 31'd100);
      do_item(skwcm_pkg::FUNC_RUN, '0, '0, 1'b1);
      do_item(skwcm_pkg::FUNC_ANSWER, 4'hF, POS_TOP, 1'b1);
      do_item(FUNC_UNUSED, 4'hF, POS_TOP, 1'b1);
      add_layer(4'd0, '0);
      add_layer(4'd15, POS_TOP);
      add_layer(4'd5, 31'd10);
      add_layer(4'd9, 31'd10);
      add_layer(4'd3, 31'd12);
      do_item(skwcm_pkg::FUNC_RUN, '0, '0, 1'b1);
      do_item(skwcm_pkg::FUNC_RUN, '0, '0, 1'b1);
      do_item(skwcm_pkg::FUNC_ADD, 4'd7, 31'd1, 1'b1);
      // Same position again, then a tie with the neighbour, then a pass over it.
      answer_head('0);
      answer_head(31'd10);
      answer_head(31'd11);
      serve_scan(10);

      // Random part: several windows, rounds of list building and scanning.
      phase = 0;
      while (sent_items < ITEM_TARGET) begin
         sel        = (phase < WINDOWS) ? phase : $urandom_range(0, WINDOWS - 1);
         gaps_on    = ($urandom_range(0, 3) != 0);
         stall_mode <= 2'($urandom_range(0, 2));
         set_window(window_start[sel], window_end[sel]);
         repeat ($urandom_range(2, 5))
            if (sent_items < ITEM_TARGET) run_scan_round();
         phase++;
      end

      settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && waiting_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
